[rtl/crti_pkg.sv]
package crti_pkg;

    // Table geometry
    localparam int TEMP_POINTS = 91;
    localparam int ROWS        = 8;
    localparam int ROW_W       = $clog2(ROWS);
    localparam int BROW_W      = ROW_W - 1;
    localparam int COL_W       = $clog2(TEMP_POINTS);
    localparam int HALF_COLS   = (TEMP_POINTS + 1) / 2;
    localparam int HCOL_W      = $clog2(HALF_COLS);
    localparam int BANK_AW     = BROW_W + HCOL_W;
    localparam int BANK_DEPTH  = 2 ** BANK_AW;
    localparam int NUM_BANKS   = 4;

    // Field widths
    localparam int VAL_W      = 18;
    localparam int TEMP_W     = 17;
    localparam int Z_W        = 16;
    localparam int TCOL_W     = 7;
    localparam int EXP_W      = 8;
    localparam int MANT_W     = 16;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_IDX_W  = 4;
    localparam int DIFF_W     = Z_W + 1;
    localparam int F_W        = TEMP_W;

    // Datapath widths
    localparam int RA_W    = 38;
    localparam int PA_W    = RA_W + DIFF_W;
    localparam int PB_W    = RA_W + 1 + DIFF_W;
    localparam int NUM_W   = PB_W + 1;
    localparam int DVS_W   = Z_W + 8;
    localparam int REM_W   = DVS_W + VAL_W;
    localparam int Y_W     = 49;
    localparam int M_W     = 32;
    localparam int POW_W   = 31;

    localparam int DIV_STEPS    = 2;
    localparam int DIV_STAGES   = VAL_W / DIV_STEPS;
    localparam int MANT_STAGES  = MANT_W;

    localparam logic [TEMP_W-1:0] T_FLOOR      = 17'd20480;
    localparam logic [COL_W-1:0]  COL_LAST     = COL_W'(TEMP_POINTS - 2);
    localparam logic [29:0]       LOG2_TEN_Q28 = 30'd891723283;
    localparam logic signed [VAL_W-1:0] RATE_MAX = 18'sh1FFFF;
    localparam logic signed [VAL_W-1:0] RATE_MIN = 18'sh20000;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_EVAL  = 1'b1;

    localparam logic signed [Z_W-1:0] BREAK_RESET [ROWS] = '{
        -16'sd27439, -16'sd19247, -16'sd15151, -16'sd13103,
        -16'sd11055, -16'sd9007,  -16'sd6959,  -16'sd4911
    };

    // Pipeline stage positions
    localparam int ST_A       = 0;
    localparam int ST_B       = 1;
    localparam int ST_C       = 2;
    localparam int ST_D       = 3;
    localparam int ST_E       = 4;
    localparam int ST_F       = 5;
    localparam int ST_DIV0    = 6;
    localparam int ST_R       = ST_DIV0 + DIV_STAGES;
    localparam int ST_Y       = ST_R + 1;
    localparam int ST_M0      = ST_Y + 1;
    localparam int ST_O       = ST_M0 + MANT_STAGES;
    localparam int NUM_STAGES = ST_O + 1;

    typedef struct packed {
        logic [REM_W-1:0]        rem;
        logic [VAL_W-1:0]        quo;
        logic [DVS_W-1:0]        dvs;
        logic                    use_byp;
        logic [VAL_W-1:0]        byp_rate;
    } div_t;

    typedef struct packed {
        logic [M_W-1:0]    m;
        logic [MANT_W-1:0] g;
        logic [VAL_W-1:0]  rate;
        logic [EXP_W-1:0]  e;
    } mant_t;

    // 2^(2^-(k+1)) in Q30
    function automatic logic [POW_W-1:0] pow_q30(input logic [3:0] k);
        logic [POW_W-1:0] t;
        case (k)
            4'd0:    t = 31'd1518500250;
            4'd1:    t = 31'd1276901417;
            4'd2:    t = 31'd1170923762;
            4'd3:    t = 31'd1121280436;
            4'd4:    t = 31'd1097253708;
            4'd5:    t = 31'd1085434106;
            4'd6:    t = 31'd1079572136;
            4'd7:    t = 31'd1076653033;
            4'd8:    t = 31'd1075196443;
            4'd9:    t = 31'd1074468888;
            4'd10:   t = 31'd1074105294;
            4'd11:   t = 31'd1073923544;
            4'd12:   t = 31'd1073832680;
            4'd13:   t = 31'd1073787251;
            4'd14:   t = 31'd1073764537;
            default: t = 31'd1073753181;
        endcase
        return t;
    endfunction

endpackage

[rtl/cooling_rate_table_interp_core.sv]
// Evaluate transactions show their result on the output register; write transactions update
// the table and give no result.
// Throughput: one transaction per cycle unless m_axis_tready stalls the output, set by the
// 34-stage pipeline with the restoring divider (two quotient bits per stage) and one
// mantissa multiplier per stage. Reset clears all valid bits and restores the metallicity
// breakpoints; the table itself is not cleared and must be written before it is read.
module cooling_rate_table_interp_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // table_row, table_col, table_value, log_temp, log_z, zero fill
    input  logic [crti_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // func
    input  logic [0:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // log_rate, pow2_exponent, mantissa, zero fill
    output logic [crti_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [crti_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [crti_pkg::Z_W-1:0]          cfg_data
);

    localparam int N = crti_pkg::NUM_STAGES;

    // ------------------------------------------------------------------
    // Breakpoint registers
    // ------------------------------------------------------------------
    logic signed [crti_pkg::Z_W-1:0] break_reg [crti_pkg::ROWS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < crti_pkg::ROWS; r++)
            begin
                break_reg[r] <= crti_pkg::BREAK_RESET[r];
            end
        end
        else if (cfg_valid && cfg_index < crti_pkg::CFG_IDX_W'(crti_pkg::ROWS))
        begin
            break_reg[cfg_index[crti_pkg::ROW_W-1:0]] <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: each stage loads when it is empty or moving on
    // ------------------------------------------------------------------
    logic [N-1:0] vld_reg;
    logic [N-1:0] vin;
    logic [N:0]   rdy;
    logic         b_func_reg;

    assign rdy[N] = m_axis_tready;

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_rdy
            assign rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    endgenerate

    always_comb
    begin
        vin = {vld_reg[N-2:0], s_axis_tvalid};
        // Write transactions leave the pipeline once the table is updated.
        vin[crti_pkg::ST_C] = vld_reg[crti_pkg::ST_B] && (b_func_reg == crti_pkg::FUNC_EVAL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= (vld_reg & ~rdy[N-1:0]) | (vin & rdy[N-1:0]);
        end
    end

    assign s_axis_tready = rdy[crti_pkg::ST_A];

    // ------------------------------------------------------------------
    // Stage A: input register
    // ------------------------------------------------------------------
    logic                               a_func_reg;
    logic [crti_pkg::ROW_W-1:0]         a_row_reg;
    logic [crti_pkg::TCOL_W-1:0]        a_col_reg;
    logic [crti_pkg::VAL_W-1:0]         a_value_reg;
    logic [crti_pkg::TEMP_W-1:0]        a_temp_reg;
    logic signed [crti_pkg::Z_W-1:0]    a_z_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[crti_pkg::ST_A])
        begin
            a_func_reg  <= s_axis_tuser[0];
            a_row_reg   <= s_axis_tdata[2:0];
            a_col_reg   <= s_axis_tdata[9:3];
            a_value_reg <= s_axis_tdata[27:10];
            a_temp_reg  <= s_axis_tdata[44:28];
            a_z_reg     <= s_axis_tdata[60:45];
        end
    end

    // ------------------------------------------------------------------
    // Stage B: temperature cell and metallicity clamp
    // ------------------------------------------------------------------
    logic [crti_pkg::ROW_W-1:0]         b_row_reg;
    logic [crti_pkg::TCOL_W-1:0]        b_wcol_reg;
    logic [crti_pkg::VAL_W-1:0]         b_value_reg;
    logic [crti_pkg::COL_W-1:0]         b_col_reg;
    logic [crti_pkg::F_W-1:0]           b_f_reg;
    logic signed [crti_pkg::Z_W-1:0]    b_z_reg;

    logic [crti_pkg::TEMP_W-1:0]        b_t;
    logic [crti_pkg::TEMP_W-1:0]        b_d;
    logic [crti_pkg::TEMP_W-9:0]        b_col_raw;
    logic [crti_pkg::COL_W-1:0]         b_col_next;
    logic [crti_pkg::F_W-1:0]           b_f_next;
    logic signed [crti_pkg::Z_W-1:0]    b_z_lo;
    logic signed [crti_pkg::Z_W-1:0]    b_z_next;

    always_comb
    begin
        b_t       = (a_temp_reg < crti_pkg::T_FLOOR) ? crti_pkg::T_FLOOR : a_temp_reg;
        b_d       = b_t - crti_pkg::T_FLOOR;
        b_col_raw = b_d[crti_pkg::TEMP_W-1:8];
        // Above the last pair of columns the last cell is extrapolated.
        if (b_col_raw > (crti_pkg::TEMP_W-8)'(crti_pkg::COL_LAST))
        begin
            b_col_next = crti_pkg::COL_LAST;
        end
        else
        begin
            b_col_next = b_col_raw[crti_pkg::COL_W-1:0];
        end
        b_f_next = b_d - (crti_pkg::F_W'(b_col_next) << 8);
        b_z_lo   = (a_z_reg < break_reg[0]) ? break_reg[0] : a_z_reg;
        b_z_next = (b_z_lo > break_reg[crti_pkg::ROWS-1]) ? break_reg[crti_pkg::ROWS-1] : b_z_lo;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[crti_pkg::ST_B])
        begin
            b_func_reg  <= a_func_reg;
            b_row_reg   <= a_row_reg;
            b_wcol_reg  <= a_col_reg;
            b_value_reg <= a_value_reg;
            b_col_reg   <= b_col_next;
            b_f_reg     <= b_f_next;
            b_z_reg     <= b_z_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: row search, table write and table read
    // The table is split by row parity and column parity into four banks,
    // so the four corners of a cell come from four different banks.
    // ------------------------------------------------------------------
    logic [crti_pkg::ROW_W-1:0]   c_i_reg;
    logic                         c_colpar_reg;
    logic [crti_pkg::F_W-1:0]     c_f_reg;
    logic signed [crti_pkg::Z_W-1:0] c_z_reg;

    logic [crti_pkg::ROWS-3:0]    c_cmp;
    logic [crti_pkg::ROW_W-1:0]   c_i_next;
    logic [crti_pkg::BROW_W-1:0]  c_row_even;
    logic [crti_pkg::BROW_W-1:0]  c_row_odd;
    logic [crti_pkg::HCOL_W-1:0]  c_col_even;
    logic [crti_pkg::HCOL_W-1:0]  c_col_odd;
    logic                         c_wr;
    logic [crti_pkg::BANK_AW-1:0] c_waddr;

    logic [crti_pkg::VAL_W-1:0]   rd_data [crti_pkg::NUM_BANKS];

    always_comb
    begin
        for (int r = 0; r < crti_pkg::ROWS - 2; r++)
        begin
            c_cmp[r] = b_z_reg > break_reg[r+1];
        end
        // The search stops at the first breakpoint that z does not exceed.
        c_i_next = crti_pkg::ROW_W'(crti_pkg::ROWS - 2);
        for (int r = crti_pkg::ROWS - 3; r >= 0; r--)
        begin
            if (!c_cmp[r])
            begin
                c_i_next = crti_pkg::ROW_W'(r);
            end
        end
        c_row_even = crti_pkg::BROW_W'(({1'b0, c_i_next} + 1'b1) >> 1);
        c_row_odd  = c_i_next[crti_pkg::ROW_W-1:1];
        c_col_even = crti_pkg::HCOL_W'(({1'b0, b_col_reg} + 1'b1) >> 1);
        c_col_odd  = crti_pkg::HCOL_W'(b_col_reg >> 1);
        c_wr       = rdy[crti_pkg::ST_C] && vld_reg[crti_pkg::ST_B]
                     && (b_func_reg == crti_pkg::FUNC_WRITE)
                     && (b_wcol_reg < crti_pkg::TCOL_W'(crti_pkg::TEMP_POINTS));
        c_waddr    = {b_row_reg[crti_pkg::ROW_W-1:1], crti_pkg::HCOL_W'(b_wcol_reg >> 1)};
    end

    genvar bk;
    generate
        for (bk = 0; bk < crti_pkg::NUM_BANKS; bk++)
        begin : g_bank
            logic [crti_pkg::VAL_W-1:0]   mem [0:crti_pkg::BANK_DEPTH-1];
            logic [crti_pkg::VAL_W-1:0]   rd_reg;
            logic [crti_pkg::BANK_AW-1:0] raddr;
            logic                         we;

            assign raddr = {(bk / 2 == 0) ? c_row_even : c_row_odd,
                            (bk % 2 == 0) ? c_col_even : c_col_odd};
            assign we    = c_wr && (b_row_reg[0] == 1'(bk / 2)) && (b_wcol_reg[0] == 1'(bk % 2));

            always_ff @(posedge clk)
            begin
                if (we)
                begin
                    mem[c_waddr] <= b_value_reg;
                end
                if (rdy[crti_pkg::ST_C])
                begin
                    rd_reg <= mem[raddr];
                end
            end

            assign rd_data[bk] = rd_reg;
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (rdy[crti_pkg::ST_C])
        begin
            c_i_reg      <= c_i_next;
            c_colpar_reg <= b_col_reg[0];
            c_f_reg      <= b_f_reg;
            c_z_reg      <= b_z_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: temperature interpolation of both rows
    // ------------------------------------------------------------------
    logic signed [crti_pkg::RA_W-1:0]   d_ra_reg;
    logic signed [crti_pkg::RA_W-1:0]   d_rb_reg;
    logic signed [crti_pkg::DIFF_W-1:0] d_den_reg;
    logic signed [crti_pkg::DIFF_W-1:0] d_dz_reg;

    logic signed [crti_pkg::VAL_W-1:0]  d_v0a, d_v1a, d_v0b, d_v1b;
    logic signed [crti_pkg::VAL_W:0]    d_da, d_db;
    logic signed [crti_pkg::F_W:0]      d_fs;
    logic signed [crti_pkg::VAL_W+crti_pkg::F_W+1:0] d_pa, d_pb;
    logic [1:0]                         d_sel_a0, d_sel_a1, d_sel_b0, d_sel_b1;
    logic [crti_pkg::ROW_W-1:0]         d_i1;

    always_comb
    begin
        d_sel_a0 = {c_i_reg[0], c_colpar_reg};
        d_sel_a1 = {c_i_reg[0], ~c_colpar_reg};
        d_sel_b0 = {~c_i_reg[0], c_colpar_reg};
        d_sel_b1 = {~c_i_reg[0], ~c_colpar_reg};
        d_v0a    = $signed(rd_data[d_sel_a0]);
        d_v1a    = $signed(rd_data[d_sel_a1]);
        d_v0b    = $signed(rd_data[d_sel_b0]);
        d_v1b    = $signed(rd_data[d_sel_b1]);
        d_da     = (crti_pkg::VAL_W+1)'(d_v1a) - (crti_pkg::VAL_W+1)'(d_v0a);
        d_db     = (crti_pkg::VAL_W+1)'(d_v1b) - (crti_pkg::VAL_W+1)'(d_v0b);
        d_fs     = $signed({1'b0, c_f_reg});
        d_pa     = d_da * d_fs;
        d_pb     = d_db * d_fs;
        d_i1     = c_i_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[crti_pkg::ST_D])
        begin
            d_ra_reg  <= (crti_pkg::RA_W'(d_v0a) <<< 8) + crti_pkg::RA_W'(d_pa);
            d_rb_reg  <= (crti_pkg::RA_W'(d_v0b) <<< 8) + crti_pkg::RA_W'(d_pb);
            d_den_reg <= crti_pkg::DIFF_W'(break_reg[d_i1]) - crti_pkg::DIFF_W'(break_reg[c_i_reg]);
            d_dz_reg  <= crti_pkg::DIFF_W'(c_z_reg) - crti_pkg::DIFF_W'(break_reg[c_i_reg]);
        end
    end

    // ------------------------------------------------------------------
    // Stage E: metallicity weighting products
    // ------------------------------------------------------------------
    logic signed [crti_pkg::PA_W-1:0]   e_pa_reg;
    logic signed [crti_pkg::PB_W-1:0]   e_pb_reg;
    logic signed [crti_pkg::RA_W-1:0]   e_ra_reg;
    logic signed [crti_pkg::DIFF_W-1:0] e_den_reg;

    logic signed [crti_pkg::RA_W:0]     e_rdiff;
    logic signed [crti_pkg::PA_W-1:0]   e_pa;
    logic signed [crti_pkg::PB_W-1:0]   e_pb;

    always_comb
    begin
        e_rdiff = (crti_pkg::RA_W+1)'(d_rb_reg) - (crti_pkg::RA_W+1)'(d_ra_reg);
        e_pa    = d_ra_reg * d_den_reg;
        e_pb    = e_rdiff * d_dz_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[crti_pkg::ST_E])
        begin
            e_pa_reg  <= e_pa;
            e_pb_reg  <= e_pb;
            e_ra_reg  <= d_ra_reg;
            e_den_reg <= d_den_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage F: numerator, saturation test and divider setup.
    // The quotient is offset by 2^17 so that an in-range floor quotient
    // becomes an 18-bit unsigned restoring division.
    // ------------------------------------------------------------------
    crti_pkg::div_t f_reg;

    logic signed [crti_pkg::NUM_W-1:0] f_num;
    logic [crti_pkg::DVS_W-1:0]        f_dvs;
    logic signed [crti_pkg::NUM_W-1:0] f_hi;
    logic signed [crti_pkg::RA_W-1:0]  f_shr;
    logic                              f_den_pos;
    crti_pkg::div_t                    f_next;

    always_comb
    begin
        f_num     = crti_pkg::NUM_W'(e_pa_reg) + crti_pkg::NUM_W'(e_pb_reg);
        f_den_pos = e_den_reg > (crti_pkg::DIFF_W)'(0);
        f_dvs     = {e_den_reg[crti_pkg::Z_W-1:0], 8'b0};
        f_hi      = crti_pkg::NUM_W'($signed({1'b0, f_dvs, 17'b0}));
        f_shr     = e_ra_reg >>> 8;

        f_next          = '0;
        f_next.dvs      = f_dvs;
        f_next.rem      = crti_pkg::REM_W'(f_num + f_hi);
        f_next.use_byp  = 1'b1;
        if (!f_den_pos)
        begin
            if (f_shr > crti_pkg::RA_W'(crti_pkg::RATE_MAX))
            begin
                f_next.byp_rate = crti_pkg::RATE_MAX;
            end
            else if (f_shr < crti_pkg::RA_W'(crti_pkg::RATE_MIN))
            begin
                f_next.byp_rate = crti_pkg::RATE_MIN;
            end
            else
            begin
                f_next.byp_rate = f_shr[crti_pkg::VAL_W-1:0];
            end
        end
        else if (f_num >= f_hi)
        begin
            f_next.byp_rate = crti_pkg::RATE_MAX;
        end
        else if (f_num < -f_hi)
        begin
            f_next.byp_rate = crti_pkg::RATE_MIN;
        end
        else
        begin
            f_next.use_byp = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[crti_pkg::ST_F])
        begin
            f_reg <= f_next;
        end
    end

    // ------------------------------------------------------------------
    // Divider: restoring division, DIV_STEPS quotient bits per stage
    // ------------------------------------------------------------------
    crti_pkg::div_t div_in  [crti_pkg::DIV_STAGES];
    crti_pkg::div_t div_reg [crti_pkg::DIV_STAGES];

    genvar dg;
    generate
        for (dg = 0; dg < crti_pkg::DIV_STAGES; dg++)
        begin : g_div
            crti_pkg::div_t div_next;

            if (dg == 0)
            begin : g_first
                assign div_in[dg] = f_reg;
            end
            else
            begin : g_rest
                assign div_in[dg] = div_reg[dg-1];
            end

            always_comb
            begin
                logic [crti_pkg::REM_W-1:0] trial;
                div_next = div_in[dg];
                for (int s = 0; s < crti_pkg::DIV_STEPS; s++)
                begin
                    trial = crti_pkg::REM_W'(div_next.dvs)
                            << (crti_pkg::VAL_W - 1 - dg * crti_pkg::DIV_STEPS - s);
                    if (div_next.rem >= trial)
                    begin
                        div_next.rem = div_next.rem - trial;
                        div_next.quo[crti_pkg::VAL_W - 1 - dg * crti_pkg::DIV_STEPS - s] = 1'b1;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[crti_pkg::ST_DIV0 + dg])
                begin
                    div_reg[dg] <= div_next;
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Stage R: final rate
    // ------------------------------------------------------------------
    logic signed [crti_pkg::VAL_W-1:0] r_rate_reg;
    crti_pkg::div_t                    r_src;

    assign r_src = div_reg[crti_pkg::DIV_STAGES-1];

    always_ff @(posedge clk)
    begin
        if (rdy[crti_pkg::ST_R])
        begin
            if (r_src.use_byp)
            begin
                r_rate_reg <= $signed(r_src.byp_rate);
            end
            else
            begin
                // Subtracting the 2^17 offset flips the top bit.
                r_rate_reg <= $signed({~r_src.quo[crti_pkg::VAL_W-1],
                                       r_src.quo[crti_pkg::VAL_W-2:0]});
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage Y: rate times log2(10), split into exponent and fraction
    // ------------------------------------------------------------------
    logic signed [crti_pkg::VAL_W-1:0]  y_rate_reg;
    logic [crti_pkg::EXP_W-1:0]         y_e_reg;
    logic [crti_pkg::MANT_W-1:0]        y_g_reg;
    logic signed [crti_pkg::Y_W-1:0]    y_prod;

    assign y_prod = r_rate_reg * $signed({1'b0, crti_pkg::LOG2_TEN_Q28});

    always_ff @(posedge clk)
    begin
        if (rdy[crti_pkg::ST_Y])
        begin
            y_rate_reg <= r_rate_reg;
            y_e_reg    <= y_prod[47:40];
            y_g_reg    <= y_prod[39:24];
        end
    end

    // ------------------------------------------------------------------
    // Mantissa: one conditional Q30 multiply per fraction bit
    // ------------------------------------------------------------------
    crti_pkg::mant_t mant_in  [crti_pkg::MANT_STAGES];
    crti_pkg::mant_t mant_reg [crti_pkg::MANT_STAGES];

    genvar mj;
    generate
        for (mj = 0; mj < crti_pkg::MANT_STAGES; mj++)
        begin : g_mant
            crti_pkg::mant_t  mant_next;
            logic [63:0]      prod;

            if (mj == 0)
            begin : g_first
                assign mant_in[mj] = '{m: crti_pkg::M_W'(1) << 30, g: y_g_reg,
                                       rate: y_rate_reg, e: y_e_reg};
            end
            else
            begin : g_rest
                assign mant_in[mj] = mant_reg[mj-1];
            end

            always_comb
            begin
                prod      = 64'(mant_in[mj].m) * 64'(crti_pkg::pow_q30(4'(mj)))
                            + (64'(1) << 29);
                mant_next = mant_in[mj];
                if (mant_in[mj].g[crti_pkg::MANT_W - 1 - mj])
                begin
                    mant_next.m = prod[61:30];
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[crti_pkg::ST_M0 + mj])
                begin
                    mant_reg[mj] <= mant_next;
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Stage O: output register
    // ------------------------------------------------------------------
    logic [crti_pkg::VAL_W-1:0]  o_rate_reg;
    logic [crti_pkg::EXP_W-1:0]  o_e_reg;
    logic [crti_pkg::MANT_W-1:0] o_mant_reg;
    crti_pkg::mant_t             o_src;
    logic [crti_pkg::M_W:0]      o_sum;
    logic [crti_pkg::M_W-15:0]   o_q;

    always_comb
    begin
        o_src = mant_reg[crti_pkg::MANT_STAGES-1];
        o_sum = (crti_pkg::M_W+1)'(o_src.m) + (crti_pkg::M_W+1)'(16384);
        o_q   = o_sum[crti_pkg::M_W:15];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[crti_pkg::ST_O])
        begin
            o_rate_reg <= o_src.rate;
            o_e_reg    <= o_src.e;
            o_mant_reg <= (o_q > (crti_pkg::M_W-14)'(16'hFFFF)) ? 16'hFFFF
                                                               : o_q[crti_pkg::MANT_W-1:0];
        end
    end

    assign m_axis_tvalid = vld_reg[crti_pkg::ST_O];
    assign m_axis_tdata  = {(crti_pkg::OUT_DATA_W - crti_pkg::VAL_W - crti_pkg::EXP_W
                             - crti_pkg::MANT_W)'(0), o_mant_reg, o_e_reg, o_rate_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_mant_norm: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[41])
        else $error("mantissa below one");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[crti_pkg::ST_R - 1] && !r_src.use_byp)
            |-> (r_src.rem < crti_pkg::REM_W'(r_src.dvs)))
        else $error("divider remainder not below divisor");

    a_exp_sign: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[crti_pkg::ST_Y] |-> (y_rate_reg[crti_pkg::VAL_W-1] == y_e_reg[crti_pkg::EXP_W-1]))
        else $error("exponent sign differs from rate sign");

    a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[crti_pkg::ST_C] && !rdy[crti_pkg::ST_D])
            |=> (vld_reg[crti_pkg::ST_C] && $stable(rd_data[0]) && $stable(rd_data[3])))
        else $error("stalled table read lost");

endmodule

[tb/tb_cooling_rate_table_interp_core.sv]
`timescale 1ns / 100ps

module tb_cooling_rate_table_interp_core;

    localparam int REG_METAL_BREAK_0 = 0;
    localparam int LAST_COL          = crti_pkg::TEMP_POINTS - 2;
    localparam int TEMP_CELL_BASE    = 20480;
    localparam int IDLE_PCT          = 26;
    localparam int STALL_LIMIT       = 5000;
    localparam int DRAIN_CYCLES      = 40;

    typedef struct packed {
        logic [crti_pkg::MANT_W-1:0]       mantissa;
        logic signed [crti_pkg::EXP_W-1:0] exponent;
        logic signed [crti_pkg::VAL_W-1:0] log_rate;
    } rate_result_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [crti_pkg::IN_DATA_W-1:0] s_axis_tdata;
    logic [0:0] s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [crti_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic [crti_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [crti_pkg::Z_W-1:0] cfg_data;

    // Shadow copies of the block's table and breakpoints.
    logic signed [crti_pkg::VAL_W-1:0] rate_table [crti_pkg::ROWS][crti_pkg::TEMP_POINTS];
    logic signed [crti_pkg::Z_W-1:0]   breaks [crti_pkg::ROWS];
    rate_result_t pending_rates [$];

    int  error_count;
    int  quiet_cycles;
    bit  steady_flow;

    longint unsigned pow_half [16] = '{
        64'd1518500250, 64'd1276901417, 64'd1170923762, 64'd1121280436,
        64'd1097253708, 64'd1085434106, 64'd1079572136, 64'd1076653033,
        64'd1075196443, 64'd1074468888, 64'd1074105294, 64'd1073923544,
        64'd1073832680, 64'd1073787251, 64'd1073764537, 64'd1073753181
    };

    cooling_rate_table_interp_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint row_interp(int row, int col, longint f);
        longint v0;
        longint v1;
        v0 = rate_table[row][col];
        v1 = rate_table[row][col + 1];
        return v0 * 256 + (v1 - v0) * f;
    endfunction

    function automatic rate_result_t interp_cooling_rate(
        logic [crti_pkg::TEMP_W-1:0] log_temp, logic signed [crti_pkg::Z_W-1:0] log_z);
        rate_result_t    r;
        longint          t, d, f, z, ra, rb, den, rate, y;
        longint unsigned uy, g, m;
        int              col, i;
        t = log_temp;
        if (t < TEMP_CELL_BASE)
            t = TEMP_CELL_BASE;
        d = t - TEMP_CELL_BASE;
        col = int'(d >>> 8);
        if (col > LAST_COL)
            col = LAST_COL;
        f = d - longint'(col) * 256;
        z = log_z;
        if (z < breaks[0])
            z = breaks[0];
        if (z > breaks[crti_pkg::ROWS-1])
            z = breaks[crti_pkg::ROWS-1];
        i = 0;
        while (i < crti_pkg::ROWS - 2 && z > breaks[i+1])
            i++;
        ra = row_interp(i, col, f);
        rb = row_interp(i + 1, col, f);
        den = longint'(breaks[i+1]) - longint'(breaks[i]);
        if (den <= 0)
            rate = floor_div(ra, 256);
        else
            rate = floor_div(ra * den + (rb - ra) * (z - breaks[i]), den * 256);
        if (rate > 131071)
            rate = 131071;
        if (rate < -131072)
            rate = -131072;
        y = rate * 64'sd891723283;
        uy = longint'(y) + (64'd128 << 40);
        g = (uy >> 24) & 64'hFFFF;
        m = 64'd1 << 30;
        for (int k = 0; k < 16; k++)
            if (g[15-k])
                m = (m * pow_half[k] + (64'd1 << 29)) >> 30;
        m = (m + (64'd1 << 14)) >> 15;
        if (m > 65535)
            m = 65535;
        r.log_rate = rate[crti_pkg::VAL_W-1:0];
        r.exponent = 8'(longint'(uy >> 40) - 128);
        r.mantissa = m[crti_pkg::MANT_W-1:0];
        return r;
    endfunction

    task automatic idle_gap();
        while (!steady_flow && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Sends one item; called right after a rising edge.
    task automatic send_item(logic func, int row, int col, int value, int temp, int z);
        idle_gap();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {3'b000, 16'(z), 17'(temp), 18'(value), 7'(col), 3'(row)};
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        @(posedge clk);
        if (func == crti_pkg::FUNC_WRITE)
        begin
            if (col < crti_pkg::TEMP_POINTS)
                rate_table[row][col] = crti_pkg::VAL_W'(value);
        end
        else
            pending_rates.push_back(interp_cooling_rate(crti_pkg::TEMP_W'(temp),
                                                        crti_pkg::Z_W'(z)));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_rates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_breaks(int b0, int b1, int b2, int b3, int b4, int b5, int b6,
                                int b7);
        int vals [crti_pkg::ROWS];
        vals = '{b0, b1, b2, b3, b4, b5, b6, b7};
        for (int i = 0; i < crti_pkg::ROWS; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= crti_pkg::CFG_IDX_W'(REG_METAL_BREAK_0 + i);
            cfg_data  <= crti_pkg::Z_W'(vals[i]);
            @(negedge clk);
            while (!cfg_ready)
                @(negedge clk);
            @(posedge clk);
            breaks[i] = crti_pkg::Z_W'(vals[i]);
            cfg_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic eval_item(int temp, int z);
        send_item(crti_pkg::FUNC_EVAL, 0, 0, 0, temp, z);
    endtask

    task automatic eval_random();
        eval_item($urandom_range(131071), $urandom_range(32767) - ($urandom_range(1) ? 32768 : 0));
    endtask

    task automatic test_fill_table();
        for (int r = 0; r < crti_pkg::ROWS; r++)
            for (int c = 0; c < crti_pkg::TEMP_POINTS; c++)
                send_item(crti_pkg::FUNC_WRITE, r, c, $urandom_range(40000) - 20000, 0, 0);
        // Out-of-range columns must leave the table alone.
        send_item(crti_pkg::FUNC_WRITE, 3, crti_pkg::TEMP_POINTS, 131071, 0, 0);
        send_item(crti_pkg::FUNC_WRITE, 7, 127, -131072, 0, 0);
        wait_drained();
    endtask

    task automatic test_directed();
        eval_item(0, -32768);
        eval_item(TEMP_CELL_BASE - 1, 32767);
        eval_item(TEMP_CELL_BASE, -27439);
        eval_item(TEMP_CELL_BASE + 255, -19247);
        eval_item(TEMP_CELL_BASE + 256, -19246);
        eval_item(TEMP_CELL_BASE + LAST_COL * 256, -4911);
        eval_item(TEMP_CELL_BASE + LAST_COL * 256 + 255, -9007);
        eval_item(TEMP_CELL_BASE + (LAST_COL + 1) * 256, -6960);
        eval_item(131071, 32767);
        eval_item(131071, -32768);
        // Extreme table entries push the rate into saturation.
        send_item(crti_pkg::FUNC_WRITE, 0, LAST_COL, 131071, 0, 0);
        send_item(crti_pkg::FUNC_WRITE, 0, LAST_COL + 1, -131072, 0, 0);
        send_item(crti_pkg::FUNC_WRITE, 1, LAST_COL, -131072, 0, 0);
        send_item(crti_pkg::FUNC_WRITE, 1, LAST_COL + 1, 131071, 0, 0);
        eval_item(131071, -32768);
        eval_item(131071, -27439 + 100);
        eval_item(TEMP_CELL_BASE + LAST_COL * 256, -32768);
        eval_item(TEMP_CELL_BASE + LAST_COL * 256 + 128, -23000);
        wait_drained();
    endtask

    task automatic test_break_settings();
        // Full range, evenly spread.
        write_breaks(-32768, -23406, -14043, -4681, 4681, 14043, 23406, 32767);
        for (int n = 0; n < 20; n++)
            eval_random();
        eval_item(131071, 32767);
        eval_item(0, -32768);
        wait_drained();
        // All breakpoints equal: every row span is degenerate.
        write_breaks(0, 0, 0, 0, 0, 0, 0, 0);
        for (int n = 0; n < 10; n++)
            eval_random();
        wait_drained();
        // Decreasing order, extremes at both ends.
        write_breaks(32767, 20000, 10000, 0, -1, -10000, -20000, -32768);
        for (int n = 0; n < 10; n++)
            eval_random();
        wait_drained();
        // Narrow steps of one unit.
        write_breaks(-4, -3, -2, -1, 0, 1, 2, 3);
        for (int z = -6; z <= 5; z++)
            eval_item($urandom_range(131071), z);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        write_breaks(-27439, -19247, -15151, -13103, -11055, -9007, -6959, -4911);
        steady_flow = 1'b1;
        for (int n = 0; n < 150; n++)
        begin
            if (n == 50)
                steady_flow = 1'b0;
            if (n == 100)
            begin
                // Hold off until every result is back.
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (pending_rates.size() != 0)
                    @(posedge clk);
            end
            if ($urandom_range(99) < 25)
                send_item(crti_pkg::FUNC_WRITE, $urandom_range(7), $urandom_range(127),
                          $urandom_range(262143) - 131072, 0, 0);
            else if ($urandom_range(3) == 0)
                eval_item($urandom_range(TEMP_CELL_BASE + 256 * crti_pkg::TEMP_POINTS),
                          $urandom_range(30000) - 30000);
            else
                eval_random();
        end
        wait_drained();
    endtask

    // Output side: random back-pressure and result checking.
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            m_axis_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        rate_result_t exp_r;
        rate_result_t got;
        forever
        begin
            @(negedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got = rate_result_t'(m_axis_tdata[41:0]);
                if (pending_rates.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    exp_r = pending_rates.pop_front();
                    if (got.log_rate !== exp_r.log_rate)
                    begin
                        $display("%0t: log_rate expected %0d actual %0d", $time,
                                 exp_r.log_rate, got.log_rate);
                        error_count++;
                    end
                    if (got.exponent !== exp_r.exponent)
                    begin
                        $display("%0t: pow2_exponent expected %0d actual %0d", $time,
                                 exp_r.exponent, got.exponent);
                        error_count++;
                    end
                    if (got.mantissa !== exp_r.mantissa)
                    begin
                        $display("%0t: mantissa expected %0d actual %0d", $time,
                                 exp_r.mantissa, got.mantissa);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(negedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        error_count   = 0;
        steady_flow   = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        for (int i = 0; i < crti_pkg::ROWS; i++)
            breaks[i] = crti_pkg::BREAK_RESET[i];
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fill_table();
        test_directed();
        test_break_settings();
        test_random_traffic();
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
